[hdl/mp_pkg.sv]
// ----------------------------------------------------------------------------
// mp_pkg
// shared constants, codes and types of the matrix power block
// ----------------------------------------------------------------------------
package mp_pkg;

  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_FRAC_BITS = 16;

  localparam int VALUE_W     = 32;
  localparam int IDX_FIELD_W = 3;
  localparam int DIM_REG_W   = 4;
  localparam int EXP_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int ACC_W       = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 2'd2;

  // request opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // accumulator saturation bounds
  localparam logic signed [ACC_W-1:0] ACC_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - 64'sd1;

  // last value of the drain counter between the last issue of a pass and the first read of the next
  localparam logic [2:0] DRAIN_LAST = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } mp_state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic load;
    logic last;
  } emit_ctl_t;

endpackage

[hdl/mp_if.sv]
// ----------------------------------------------------------------------------
// mp_if
// request and result channels of the matrix power block
// ----------------------------------------------------------------------------
interface mp_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic signed [31:0] element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mp_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [2:0]  result_row;
  logic [2:0]  result_col;
  logic        last_flag;
  logic        index_error;

  modport source (output valid, result_value, result_row, result_col, last_flag,
                  index_error, input ready);
  modport sink   (input valid, result_value, result_row, result_col, last_flag,
                  index_error, output ready);
endinterface

[hdl/mp_mac.sv]
// ----------------------------------------------------------------------------
// mp_mac
// shared multiply-accumulate unit with saturation and fixed-point rescale
// ----------------------------------------------------------------------------
module mp_mac import mp_pkg::*; #(
  parameter int AW        = 6,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctl_t                  ctl_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [VALUE_W-1:0] a_i,
  input  logic signed [VALUE_W-1:0] b_i,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic [VALUE_W-1:0]        wr_data_o
);

  mac_ctl_t                  ctl_p_q, ctl_a_q;
  logic [AW-1:0]             addr_p_q, addr_a_q;
  logic signed [ACC_W-1:0]   p_d, p_q;
  logic signed [ACC_W-1:0]   sum, acc_d, acc_q;
  logic signed [ACC_W-1:0]   scaled;
  logic [ACC_W-VALUE_W:0]    upper;

  assign p_d = a_i * b_i;

  // wide add, then clamp to the accumulator range
  always_comb begin
    sum = (ctl_p_q.first ? '0 : acc_q) + p_q;
    if (sum > ACC_HI) begin
      acc_d = ACC_HI;
    end else if (sum < ACC_LO) begin
      acc_d = ACC_LO;
    end else begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p_q <= '0;
      ctl_a_q <= '0;
    end else begin
      ctl_p_q <= ctl_i;
      ctl_a_q <= ctl_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    addr_p_q <= waddr_i;
    addr_a_q <= addr_p_q;
    if (ctl_p_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // floor shift, then saturate to 32 bits
  always_comb begin
    scaled = acc_q >>> FRAC_BITS;
    upper  = scaled[ACC_W-1:VALUE_W-1];
    if ((&upper) || !(|upper)) begin
      wr_data_o = scaled[VALUE_W-1:0];
    end else if (scaled[ACC_W-1]) begin
      wr_data_o = 32'h8000_0000;
    end else begin
      wr_data_o = 32'h7FFF_FFFF;
    end
  end

  assign wr_en_o   = ctl_a_q.valid && ctl_a_q.last;
  assign wr_addr_o = addr_a_q;

endmodule

[hdl/mp_ctrl.sv]
// ----------------------------------------------------------------------------
// mp_ctrl
// sequencer: multiply passes over the shared unit, then result emission
// ----------------------------------------------------------------------------
module mp_ctrl import mp_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int CNT_W   = $clog2(MAX_DIM + 1),
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             square_i,
  input  logic [CNT_W-1:0] rows_i,
  input  logic [CNT_W-1:0] cols_i,
  input  logic [EXP_W-1:0] exponent_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output mac_ctl_t         mac_o,
  output logic [AW-1:0]    waddr_o,
  output logic [AW-1:0]    addr_a_o,
  output logic [AW-1:0]    addr_b_o,
  output logic             first_pass_o,
  output logic             cur_o,
  output emit_ctl_t        emit_o,
  output logic [IDX_W-1:0] row_o,
  output logic [IDX_W-1:0] col_o
);

  mp_state_e        state_d, state_q;
  logic [IDX_W-1:0] i_d, i_q, j_d, j_q, k_d, k_q;
  logic [EXP_W-1:0] e_d, e_q;
  logic [2:0]       drain_d, drain_q;
  logic             first_d, first_q, cur_d, cur_q;
  logic             j_last, k_last_n, i_last, k_last_c, pass_done, emit_done, drain_done;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  assign j_last     = CNT_W'(j_q) == (rows_i - 1'b1);
  assign k_last_n   = CNT_W'(k_q) == (rows_i - 1'b1);
  assign i_last     = CNT_W'(i_q) == (rows_i - 1'b1);
  assign k_last_c   = CNT_W'(k_q) == (cols_i - 1'b1);
  assign pass_done  = j_last && k_last_n && i_last;
  assign emit_done  = i_last && k_last_c;
  assign drain_done = drain_q == DRAIN_LAST;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (square_i && exponent_i >= 8'd2) ? ST_MUL : ST_EMIT_RD;
        end
      end
      ST_MUL: begin
        if (pass_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = (e_q == 8'd1) ? ST_EMIT_RD : ST_MUL;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free_i) begin
          state_d = emit_done ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // counters and outputs
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    e_d     = e_q;
    drain_d = drain_q;
    first_d = first_q;
    cur_d   = cur_q;
    mac_o   = '0;
    emit_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          e_d     = exponent_i - 8'd1;
          first_d = 1'b1;
        end
      end
      ST_MUL: begin
        mac_o.valid = 1'b1;
        mac_o.first = (j_q == '0);
        mac_o.last  = j_last;
        drain_d     = '0;
        if (!j_last) begin
          j_d = j_q + 1'b1;
        end else begin
          j_d = '0;
          if (!k_last_n) begin
            k_d = k_q + 1'b1;
          end else begin
            k_d = '0;
            i_d = i_last ? '0 : i_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_done) begin
          cur_d   = !cur_q;
          first_d = 1'b0;
          e_d     = e_q - 8'd1;
        end
      end
      ST_EMIT_RD: ;
      ST_EMIT_WR: begin
        if (out_free_i) begin
          emit_o.load = 1'b1;
          emit_o.last = emit_done;
          if (!k_last_c) begin
            k_d = k_q + 1'b1;
          end else begin
            k_d = '0;
            i_d = i_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      e_q     <= '0;
      drain_q <= '0;
      first_q <= 1'b0;
      cur_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      e_q     <= e_d;
      drain_q <= drain_d;
      first_q <= first_d;
      cur_q   <= cur_d;
    end
  end

  assign busy_o       = state_q != ST_IDLE;
  assign waddr_o      = addr_of(i_q, k_q);
  assign addr_a_o     = (state_q == ST_MUL) ? addr_of(i_q, j_q) : addr_of(i_q, k_q);
  assign addr_b_o     = addr_of(j_q, k_q);
  assign first_pass_o = first_q;
  assign cur_o        = cur_q;
  assign row_o        = i_q;
  assign col_o        = k_q;

endmodule

[hdl/matrix_power.sv]
// latency: a load is acknowledged in the cycle after it is accepted
// compute: square n x n with exponent e >= 2 runs e-1 passes of n^3 multiply-accumulates and a drain,
//   one multiply-accumulate per cycle on the single shared unit, then emits
//   rows*cols results, each through a read state and a write state, held under back-pressure
// no new request is taken until the last result leaves
// reset: configuration back to 1/1/1 and control cleared; matrix stores stay undefined
// ----------------------------------------------------------------------------
// matrix_power
// matrix loader and power unit by repeated multiplication, signed fixed point
// ----------------------------------------------------------------------------
module matrix_power import mp_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mp_req_if.sink                req,
  mp_rsp_if.source              rsp
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRAC_BITS;

  // configuration registers
  logic [DIM_REG_W-1:0] row_cnt_q, col_cnt_q;
  logic [EXP_W-1:0]     exp_q;

  // three element stores: loaded matrix and two ping-pong product buffers
  logic [VALUE_W-1:0] src_mem [DEPTH];
  logic [VALUE_W-1:0] pw0_mem [DEPTH];
  logic [VALUE_W-1:0] pw1_mem [DEPTH];
  logic [VALUE_W-1:0] src_rda_q, src_rdb_q, pw0_rd_q, pw1_rd_q;

  logic [CNT_W-1:0]   rows, cols;
  logic               square, out_free, req_fire, load_fire, start, load_bad;
  logic [AW-1:0]      load_addr;

  logic               busy, first_pass, cur;
  mac_ctl_t           mac_ctl, mac_ctl_d1_q;
  emit_ctl_t          emit;
  logic [AW-1:0]      waddr, waddr_d1_q, addr_a, addr_b;
  logic [IDX_W-1:0]   emit_row, emit_col;
  logic [VALUE_W-1:0] left_op, emit_value;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // result register
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [2:0]         out_row_q, out_col_q;
  logic               out_last_q, out_err_q;

  // size registers: zero acts as one, anything above the array size saturates
  assign rows = (row_cnt_q == '0) ? CNT_W'(1) :
                (32'(row_cnt_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(row_cnt_q);
  assign cols = (col_cnt_q == '0) ? CNT_W'(1) :
                (32'(col_cnt_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(col_cnt_q);
  assign square = rows == cols;

  // handshake: idle and a free result slot (or one being emptied now)
  assign out_free  = !out_valid_q || rsp.ready;
  assign req.ready = !busy && out_free;
  assign req_fire  = req.valid && req.ready;
  assign load_fire = req_fire && (req.opcode == OP_LOAD);
  assign start     = req_fire && (req.opcode == OP_COMPUTE);

  // load bound check against the active size
  assign load_bad  = (32'(req.row_index) >= 32'(rows)) || (32'(req.col_index) >= 32'(cols));
  assign load_addr = AW'(32'(req.row_index) * MAX_DIM + 32'(req.col_index));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_REG_W'(1);
      col_cnt_q <= DIM_REG_W'(1);
      exp_q     <= EXP_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT: row_cnt_q <= cfg_wdata_i[DIM_REG_W-1:0];
        CFG_COL_COUNT: col_cnt_q <= cfg_wdata_i[DIM_REG_W-1:0];
        CFG_EXPONENT:  exp_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mp_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W),
    .AW      (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .square_i     (square),
    .rows_i       (rows),
    .cols_i       (cols),
    .exponent_i   (exp_q),
    .out_free_i   (out_free),
    .busy_o       (busy),
    .mac_o        (mac_ctl),
    .waddr_o      (waddr),
    .addr_a_o     (addr_a),
    .addr_b_o     (addr_b),
    .first_pass_o (first_pass),
    .cur_o        (cur),
    .emit_o       (emit),
    .row_o        (emit_row),
    .col_o        (emit_col)
  );

  // loaded matrix: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (load_fire && !load_bad) begin
      src_mem[load_addr] <= req.element_value;
    end
    src_rda_q <= src_mem[addr_a];
    src_rdb_q <= src_mem[addr_b];
  end

  // product buffers: the pass writes the one not holding the latest power
  always_ff @(posedge clk_i) begin
    if (wr_en && !cur) begin
      pw1_mem[wr_addr] <= wr_data;
    end
    if (wr_en && cur) begin
      pw0_mem[wr_addr] <= wr_data;
    end
    pw0_rd_q <= pw0_mem[addr_a];
    pw1_rd_q <= pw1_mem[addr_a];
  end

  // issue control is registered to line up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_ctl_d1_q <= '0;
    end else begin
      mac_ctl_d1_q <= mac_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_d1_q <= waddr;
  end

  // first pass multiplies the loaded matrix by itself
  assign left_op = first_pass ? src_rda_q : (cur ? pw1_rd_q : pw0_rd_q);

  mp_mac #(
    .AW        (AW),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl_d1_q),
    .waddr_i   (waddr_d1_q),
    .a_i       (left_op),
    .b_i       (src_rdb_q),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  // emitted element: zeros if not square, identity for power zero,
  // the loaded matrix for power one, otherwise the latest product
  always_comb begin
    if (!square) begin
      emit_value = '0;
    end else if (exp_q == '0) begin
      emit_value = (emit_row == emit_col) ? ONE : '0;
    end else if (exp_q == EXP_W'(1)) begin
      emit_value = src_rda_q;
    end else begin
      emit_value = cur ? pw1_rd_q : pw0_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_fire || emit.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      out_value_q <= '0;
      out_row_q   <= req.row_index;
      out_col_q   <= req.col_index;
      out_last_q  <= 1'b1;
      out_err_q   <= load_bad;
    end else if (emit.load) begin
      out_value_q <= emit_value;
      out_row_q   <= 3'(emit_row);
      out_col_q   <= 3'(emit_col);
      out_last_q  <= emit.last;
      out_err_q   <= 1'b0;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.result_value = out_value_q;
  assign rsp.result_row   = out_row_q;
  assign rsp.result_col   = out_col_q;
  assign rsp.last_flag    = out_last_q;
  assign rsp.index_error  = out_err_q;

endmodule

[hdl/mp_checker.sv]
// ----------------------------------------------------------------------------
// mp_checker
// port-level checks of the matrix power block, bound to the top level
// ----------------------------------------------------------------------------
module mp_checker import mp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_opcode_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic signed [31:0] rsp_value_i,
  input logic               rsp_last_i,
  input logic               rsp_err_i
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // a load request is acknowledged in the next cycle
  a_load_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_LOAD)
    |=> rsp_valid_i && rsp_last_i && (rsp_value_i == 32'sd0))
    else $error("load not acknowledged");

  // an index error only ever rides on a result with the last flag, such as a load acknowledgement
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_err_i |-> rsp_last_i)
    else $error("index error without last flag");

  // a compute request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_COMPUTE) |=> !req_ready_i)
    else $error("ready during compute");

endmodule

bind matrix_power mp_checker u_mp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .req_opcode_i (req.opcode),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_value_i  (rsp.result_value),
  .rsp_last_i   (rsp.last_flag),
  .rsp_err_i    (rsp.index_error)
);
